[hdl/mcrp_pkg.sv]
package mcrp_pkg;

	localparam int POS_W   = 30;
	localparam int PRICE_W = 20;
	localparam int COST_W  = 52;
	localparam int CFG_W   = 30;
	localparam int IDX_W   = 2;
	localparam int FUEL_W  = 34;
	localparam int PROD_W  = POS_W + PRICE_W;

	localparam logic [IDX_W-1:0] REG_TANK  = 2'd0;
	localparam logic [IDX_W-1:0] REG_START = 2'd1;
	localparam logic [IDX_W-1:0] REG_ROUTE = 2'd2;

	localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

	typedef struct packed {
		logic load;
		logic ovf_set;
		logic ins_rd;
		logic ins_shift;
		logic ins_put;
		logic nc_init;
		logic nc_rd;
		logic nc_pop;
		logic nc_push;
		logic nc_top;
		logic dr_init;
		logic dr_rd;
		logic dr_nc;
		logic dr_need;
		logic dr_mul;
		logic dr_add;
		logic dr_end;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic last;
		logic j_zero;
		logic shift;
		logic pop;
		logic k_one;
		logic i_last;
		logic fuel_neg;
		logic out_free;
	} sts_t;

endpackage

[hdl/mcrp_ifs.sv]
interface mcrp_station_if;
	import mcrp_pkg::*;
	logic               valid;
	logic               ready;
	logic [POS_W-1:0]   station_position;
	logic [PRICE_W-1:0] station_price;
	logic               last_station;
	modport source (output valid, station_position, station_price, last_station, input ready);
	modport sink (input valid, station_position, station_price, last_station, output ready);
endinterface

interface mcrp_plan_if;
	import mcrp_pkg::*;
	logic              valid;
	logic              ready;
	logic [COST_W-1:0] total_cost;
	logic              unreachable;
	logic              overflow;
	modport source (output valid, total_cost, unreachable, overflow, input ready);
	modport sink (input valid, total_cost, unreachable, overflow, output ready);
endinterface

[hdl/mcrp_dp.sv]
module mcrp_dp #(
	parameter int MAX_STATIONS = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mcrp_pkg::cmd_t                 cmd,
	output mcrp_pkg::sts_t                 sts,
	input  logic                           cfg_we,
	input  logic [mcrp_pkg::IDX_W-1:0]     cfg_index,
	input  logic [mcrp_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [mcrp_pkg::POS_W-1:0]     station_position,
	input  logic [mcrp_pkg::PRICE_W-1:0]   station_price,
	input  logic                           last_station,
	input  logic                           plan_ready,
	output logic                           plan_valid,
	output logic [mcrp_pkg::COST_W-1:0]    total_cost,
	output logic                           unreachable,
	output logic                           overflow
);
	import mcrp_pkg::*;

	localparam int AW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
	localparam int CW = $clog2(MAX_STATIONS + 1);
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STATIONS);
	localparam int PP_W = POS_W + PRICE_W;
	localparam int STK_W = AW + PRICE_W;

	logic [PP_W-1:0]  pp_mem [MAX_STATIONS];
	logic [CW-1:0]    nc_mem [MAX_STATIONS];
	logic [STK_W-1:0] stk_mem [MAX_STATIONS];

	logic [PP_W-1:0]    pp_rd_q;
	logic [CW-1:0]      nc_rd_q;
	logic [STK_W-1:0]   stk_rd_q;
	logic [CFG_W-1:0]   cap_q, start_q, route_q;
	logic [CW-1:0]      cnt_q, j_q, k_q, depth_q, i_q;
	logic               ovf_q, last_q, out_valid_q;
	logic [PP_W-1:0]    newp_q;
	logic [STK_W-1:0]   top_q;
	logic signed [FUEL_W-1:0] fuel_q;
	logic [POS_W-1:0]   prev_q, pos_i_q;
	logic [PRICE_W-1:0] price_i_q;
	logic [CW-1:0]      nc_i_q;
	logic [POS_W-1:0]   def_q;
	logic [PROD_W-1:0]  prod_q;
	logic [COST_W-1:0]  cost_q;

	logic [POS_W-1:0]   pos_clamp, rd_pos, target, span, need;
	logic [PRICE_W-1:0] rd_price;
	logic [CW-1:0]      j_dec, k_dec, depth_dec, depth_m2, i_inc;
	logic [COST_W:0]    cost_sum;
	logic signed [FUEL_W-1:0] need_s;

	assign rd_pos    = pp_rd_q[PP_W-1:PRICE_W];
	assign rd_price  = pp_rd_q[PRICE_W-1:0];
	assign pos_clamp = (station_position > route_q) ? route_q : station_position;
	assign j_dec     = j_q - CW'(1);
	assign k_dec     = k_q - CW'(1);
	assign depth_dec = depth_q - CW'(1);
	assign depth_m2  = depth_q - CW'(2);
	assign i_inc     = i_q + CW'(1);
	assign target    = (nc_i_q >= cnt_q) ? route_q : rd_pos;
	assign span      = target - pos_i_q;
	assign need      = (span > cap_q) ? cap_q : span;
	assign need_s    = $signed({{(FUEL_W-POS_W){1'b0}}, need});
	assign cost_sum  = {1'b0, cost_q} + {{(COST_W+1-PROD_W){1'b0}}, prod_q};

	assign sts.full     = (cnt_q == MAX_CNT);
	assign sts.last     = last_q;
	assign sts.j_zero   = (j_q == '0);
	assign sts.shift    = (rd_pos > newp_q[PP_W-1:PRICE_W]);
	assign sts.pop      = (depth_q != '0) && (top_q[PRICE_W-1:0] >= rd_price);
	assign sts.k_one    = (k_q == CW'(1));
	assign sts.i_last   = (i_inc == cnt_q);
	assign sts.fuel_neg = fuel_q[FUEL_W-1];
	assign sts.out_free = !out_valid_q || plan_ready;

	assign plan_valid = out_valid_q;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.ins_shift) begin
			pp_mem[j_q[AW-1:0]] <= pp_rd_q;
		end else if (cmd.ins_put) begin
			pp_mem[j_q[AW-1:0]] <= newp_q;
		end
		if (cmd.ins_rd) begin
			pp_rd_q <= pp_mem[j_dec[AW-1:0]];
		end else if (cmd.nc_rd) begin
			pp_rd_q <= pp_mem[k_dec[AW-1:0]];
		end else if (cmd.dr_rd) begin
			pp_rd_q <= pp_mem[i_q[AW-1:0]];
		end else if (cmd.dr_nc) begin
			pp_rd_q <= pp_mem[nc_rd_q[AW-1:0]];
		end
		if (cmd.nc_push) begin
			nc_mem[k_dec[AW-1:0]] <= (depth_q == '0) ? cnt_q
				: CW'(top_q[STK_W-1:PRICE_W]);
		end
		if (cmd.dr_rd) begin
			nc_rd_q <= nc_mem[i_q[AW-1:0]];
		end
		if (cmd.nc_push && depth_q != '0) begin
			stk_mem[depth_dec[AW-1:0]] <= top_q;
		end
		if (cmd.nc_pop) begin
			stk_rd_q <= stk_mem[depth_m2[AW-1:0]];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= '0;
			start_q     <= '0;
			route_q     <= '0;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TANK:  cap_q   <= cfg_wdata;
					REG_START: start_q <= cfg_wdata;
					REG_ROUTE: route_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.ovf_set) ovf_q <= 1'b1;
			if (cmd.ins_put) cnt_q <= cnt_q + CW'(1);
			if (plan_ready) out_valid_q <= 1'b0;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
				cnt_q       <= '0;
				ovf_q       <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			newp_q <= {pos_clamp, station_price};
			last_q <= last_station;
			j_q    <= cnt_q;
		end
		if (cmd.ins_shift) j_q <= j_dec;
		if (cmd.nc_init) begin
			depth_q <= '0;
			k_q     <= cnt_q;
		end
		if (cmd.nc_pop) depth_q <= depth_dec;
		if (cmd.nc_top) top_q <= stk_rd_q;
		if (cmd.nc_push) begin
			top_q   <= {k_dec[AW-1:0], rd_price};
			depth_q <= depth_q + CW'(1);
			k_q     <= k_dec;
		end
		if (cmd.dr_init) begin
			i_q    <= '0;
			fuel_q <= $signed({{(FUEL_W-CFG_W){1'b0}}, start_q});
			prev_q <= '0;
			cost_q <= '0;
		end
		if (cmd.dr_nc) begin
			pos_i_q   <= rd_pos;
			price_i_q <= rd_price;
			nc_i_q    <= nc_rd_q;
			prev_q    <= rd_pos;
			fuel_q    <= fuel_q - $signed({{(FUEL_W-POS_W){1'b0}}, rd_pos})
				+ $signed({{(FUEL_W-POS_W){1'b0}}, prev_q});
		end
		if (cmd.dr_need) begin
			if (need_s > fuel_q) begin
				def_q  <= need - fuel_q[POS_W-1:0];
				fuel_q <= need_s;
			end else begin
				def_q <= '0;
			end
		end
		if (cmd.dr_mul) prod_q <= def_q * price_i_q;
		if (cmd.dr_add) begin
			cost_q <= cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
			i_q    <= i_inc;
		end
		if (cmd.dr_end) begin
			fuel_q <= fuel_q - $signed({{(FUEL_W-POS_W){1'b0}}, route_q})
				+ $signed({{(FUEL_W-POS_W){1'b0}}, prev_q});
		end
		if (cmd.emit) begin
			total_cost  <= fuel_q[FUEL_W-1] ? '0 : cost_q;
			unreachable <= fuel_q[FUEL_W-1];
			overflow    <= ovf_q;
		end
	end

endmodule

[hdl/mcrp_ctrl.sv]
module mcrp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  mcrp_pkg::sts_t sts,
	output mcrp_pkg::cmd_t cmd
);
	import mcrp_pkg::*;

	typedef enum logic [15:0] {
		S_IDLE     = 16'b0000_0000_0000_0001,
		S_LOAD_CHK = 16'b0000_0000_0000_0010,
		S_INS_CMP  = 16'b0000_0000_0000_0100,
		S_NC_INIT  = 16'b0000_0000_0000_1000,
		S_NC_RD    = 16'b0000_0000_0001_0000,
		S_NC_CMP   = 16'b0000_0000_0010_0000,
		S_NC_POP   = 16'b0000_0000_0100_0000,
		S_DR_INIT  = 16'b0000_0000_1000_0000,
		S_DR_RD    = 16'b0000_0001_0000_0000,
		S_DR_NC    = 16'b0000_0010_0000_0000,
		S_DR_CHK   = 16'b0000_0100_0000_0000,
		S_DR_MUL   = 16'b0000_1000_0000_0000,
		S_DR_ADD   = 16'b0001_0000_0000_0000,
		S_DR_END   = 16'b0010_0000_0000_0000,
		S_DR_FIN   = 16'b0100_0000_0000_0000,
		S_RESULT   = 16'b1000_0000_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_LOAD_CHK;
				end
			end
			S_LOAD_CHK: begin
				if (sts.full) begin
					cmd.ovf_set = 1'b1;
					state_d     = sts.last ? S_NC_INIT : S_IDLE;
				end else if (sts.j_zero) begin
					cmd.ins_put = 1'b1;
					state_d     = sts.last ? S_NC_INIT : S_IDLE;
				end else begin
					cmd.ins_rd = 1'b1;
					state_d    = S_INS_CMP;
				end
			end
			S_INS_CMP: begin
				if (sts.shift) begin
					cmd.ins_shift = 1'b1;
					state_d       = S_LOAD_CHK;
				end else begin
					cmd.ins_put = 1'b1;
					state_d     = sts.last ? S_NC_INIT : S_IDLE;
				end
			end
			S_NC_INIT: begin
				cmd.nc_init = 1'b1;
				state_d     = S_NC_RD;
			end
			S_NC_RD: begin
				cmd.nc_rd = 1'b1;
				state_d   = S_NC_CMP;
			end
			S_NC_CMP: begin
				if (sts.pop) begin
					cmd.nc_pop = 1'b1;
					state_d    = S_NC_POP;
				end else begin
					cmd.nc_push = 1'b1;
					state_d     = sts.k_one ? S_DR_INIT : S_NC_RD;
				end
			end
			S_NC_POP: begin
				cmd.nc_top = 1'b1;
				state_d    = S_NC_CMP;
			end
			S_DR_INIT: begin
				cmd.dr_init = 1'b1;
				state_d     = S_DR_RD;
			end
			S_DR_RD: begin
				cmd.dr_rd = 1'b1;
				state_d   = S_DR_NC;
			end
			S_DR_NC: begin
				cmd.dr_nc = 1'b1;
				state_d   = S_DR_CHK;
			end
			S_DR_CHK: begin
				if (sts.fuel_neg) begin
					state_d = S_RESULT;
				end else begin
					cmd.dr_need = 1'b1;
					state_d     = S_DR_MUL;
				end
			end
			S_DR_MUL: begin
				cmd.dr_mul = 1'b1;
				state_d    = S_DR_ADD;
			end
			S_DR_ADD: begin
				cmd.dr_add = 1'b1;
				state_d    = sts.i_last ? S_DR_END : S_DR_RD;
			end
			S_DR_END: begin
				cmd.dr_end = 1'b1;
				state_d    = S_DR_FIN;
			end
			S_DR_FIN: begin
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/min_cost_refuel_planner.sv]
// a beat without last_station is stored by insertion into position order, stepping past each
// stored station with a greater position (insertion through one memory port)
// a last beat then plans: a pass that finds each station's next cheaper station with a stack,
// then the drive pass through the shared 30x20 multiplier, and then the result
// one beat at a time; reset clears control state only, registers read 0, no memory sweep
module min_cost_refuel_planner #(
	parameter int MAX_STATIONS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	mcrp_station_if.sink               stations,
	mcrp_plan_if.source                plan,
	input  logic                       cfg_we,
	input  logic [mcrp_pkg::IDX_W-1:0] cfg_index,
	input  logic [mcrp_pkg::CFG_W-1:0] cfg_wdata
);
	import mcrp_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign stations.ready = in_ready;

	mcrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stations.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mcrp_dp #(
		.MAX_STATIONS (MAX_STATIONS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.station_position (stations.station_position),
		.station_price    (stations.station_price),
		.last_station     (stations.last_station),
		.plan_ready       (plan.ready),
		.plan_valid       (plan.valid),
		.total_cost       (plan.total_cost),
		.unreachable      (plan.unreachable),
		.overflow         (plan.overflow)
	);

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !stations.ready)
		else $error("accepted a beat while the previous one is still being stored");

	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> plan.valid)
		else $error("result not presented after emit");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins_put && cmd.ins_shift))
		else $error("two writes to the station memory in one cycle");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!plan.valid || plan.ready))
		else $error("result overwritten before it was taken");

endmodule
